// ===== hdl/mbrtu_pkg.sv =====
`default_nettype none

package mbrtu_pkg;

  // buffer bound and derived counter width
  localparam int unsigned MaxFrameBytes = 256;
  localparam int unsigned CountW        = $clog2(MaxFrameBytes + 1);
  localparam int unsigned MinFrameBytes = 4;

  // fixed field widths
  localparam int unsigned ByteW   = 8;
  localparam int unsigned StatusW = 3;
  localparam int unsigned LenW    = 9;
  localparam int unsigned CrcW    = 16;

  // modbus crc-16, reflected
  localparam logic [CrcW-1:0] CrcPreset = 16'hFFFF;
  localparam logic [CrcW-1:0] CrcPoly   = 16'hA001;

  // reset value of the slave address register
  localparam logic [ByteW-1:0] SlaveAddrReset = 8'h01;

  // verdict codes
  typedef enum logic [StatusW-1:0] {
    ST_ACCEPTED  = 3'd0,
    ST_CRC_ERROR = 3'd1,
    ST_OTHER_ADR = 3'd2,
    ST_TOO_SHORT = 3'd3,
    ST_OVERFLOW  = 3'd4
  } frame_status_e;

endpackage

`default_nettype wire

// ===== hdl/mbrtu_if.sv =====
`default_nettype none

// received byte channel
interface mbrtu_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       end_of_frame;

  modport source (output valid, output rx_byte, output end_of_frame, input ready);
  modport sink   (input valid, input rx_byte, input end_of_frame, output ready);
endinterface

// frame verdict channel
interface mbrtu_res_if;
  logic       valid;
  logic       ready;
  logic [2:0] frame_status;
  logic [7:0] frame_address;
  logic [8:0] frame_length;

  modport source (output valid, output frame_status, output frame_address,
                  output frame_length, input ready);
  modport sink   (input valid, input frame_status, input frame_address,
                  input frame_length, output ready);
endinterface

// slave address write channel
interface mbrtu_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] slave_address;

  modport source (output valid, output slave_address, input ready);
  modport sink   (input valid, input slave_address, output ready);
endinterface

`default_nettype wire

// ===== hdl/modbus_rtu_frame_checker.sv =====
// channel   dir  handshake      payload
// rx_i      in   valid/ready    rx_byte[7:0], end_of_frame
// res_o     out  valid/ready    frame_status[2:0], frame_address[7:0], frame_length[8:0]
// cfg_i     in   valid/ready    slave_address[7:0]
//
// one byte per cycle unless a waiting verdict stalls; the crc step is eight bit steps
// of logic on the frame registers; the verdict is registered with the end-of-frame byte
// a new byte is taken while a verdict waits, unless that verdict is stalled
// rst_ni clears the frame state and sets the slave address to 1; cfg_i is always ready

`default_nettype none

module modbus_rtu_frame_checker
  import mbrtu_pkg::*;
(
  input  wire          clk_i,
  input  wire          rst_ni,
  mbrtu_rx_if.sink     rx_i,
  mbrtu_res_if.source  res_o,
  mbrtu_cfg_if.sink    cfg_i
);

  logic [ByteW-1:0]  slave_addr_q;
  logic [CrcW-1:0]   crc_q, crc_d, crc_fed;
  logic [ByteW-1:0]  old_q, old_d;
  logic [ByteW-1:0]  new_q, new_d;
  logic [CountW-1:0] cnt_q, cnt_d;
  logic [ByteW-1:0]  addr_q, addr_d;
  logic              ovf_q, ovf_d;

  logic              res_valid_q;
  frame_status_e     status_q, status_d;
  logic [ByteW-1:0]  res_addr_q;
  logic [LenW-1:0]   res_len_q;

  logic              in_ready;
  logic              accept;
  logic              at_limit;
  logic [CrcW-1:0]   rx_crc;

  assign cfg_i.ready = 1'b1;

  // slave address register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slave_addr_q <= SlaveAddrReset;
    end else if (cfg_i.valid) begin
      slave_addr_q <= cfg_i.slave_address;
    end
  end

  // take a byte when the result register is free or being drained
  assign in_ready   = !res_valid_q || res_o.ready;
  assign rx_i.ready = in_ready;
  assign accept     = rx_i.valid && in_ready;

  mbrtu_crc_step u_crc (
    .crc_i  (crc_q),
    .data_i (old_q),
    .crc_o  (crc_fed)
  );

  // frame state after this byte
  assign at_limit = cnt_q >= CountW'(MaxFrameBytes);
  assign crc_d    = (cnt_q >= CountW'(2)) ? crc_fed : crc_q;
  assign addr_d   = (cnt_q == '0) ? rx_i.rx_byte : addr_q;
  assign old_d    = new_q;
  assign new_d    = rx_i.rx_byte;
  assign ovf_d    = ovf_q || at_limit;
  assign cnt_d    = at_limit ? cnt_q : cnt_q + CountW'(1);
  assign rx_crc   = {new_d, old_d};

  // verdict by priority
  always_comb begin
    if (ovf_d) begin
      status_d = ST_OVERFLOW;
    end else if (cnt_d < CountW'(MinFrameBytes)) begin
      status_d = ST_TOO_SHORT;
    end else if (rx_crc != crc_d) begin
      status_d = ST_CRC_ERROR;
    end else if (addr_d != slave_addr_q) begin
      status_d = ST_OTHER_ADR;
    end else begin
      status_d = ST_ACCEPTED;
    end
  end

  // frame registers, cleared at end of frame
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q  <= CrcPreset;
      old_q  <= '0;
      new_q  <= '0;
      cnt_q  <= '0;
      addr_q <= '0;
      ovf_q  <= 1'b0;
    end else if (accept) begin
      if (rx_i.end_of_frame) begin
        crc_q  <= CrcPreset;
        old_q  <= '0;
        new_q  <= '0;
        cnt_q  <= '0;
        addr_q <= '0;
        ovf_q  <= 1'b0;
      end else begin
        crc_q  <= crc_d;
        old_q  <= old_d;
        new_q  <= new_d;
        cnt_q  <= cnt_d;
        addr_q <= addr_d;
        ovf_q  <= ovf_d;
      end
    end
  end

  // result valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (accept && rx_i.end_of_frame) begin
      res_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (accept && rx_i.end_of_frame) begin
      status_q   <= status_d;
      res_addr_q <= addr_d;
      res_len_q  <= LenW'(cnt_d);
    end
  end

  assign res_o.valid         = res_valid_q;
  assign res_o.frame_status  = status_q;
  assign res_o.frame_address = res_addr_q;
  assign res_o.frame_length  = res_len_q;

  // checks
  a_eof_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && rx_i.end_of_frame) |=> res_valid_q)
    else $error("end of frame request gave no verdict");

  a_eof_clears_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && rx_i.end_of_frame) |=> (cnt_q == '0) && !ovf_q && (crc_q == CrcPreset))
    else $error("frame state not cleared after end of frame");

  a_ovf_at_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovf_q |-> (cnt_q == CountW'(MaxFrameBytes)))
    else $error("overflow set below the buffer bound");

  a_stall_only_on_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready |-> res_valid_q)
    else $error("input stalled with an empty result register");

  a_accepted_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && (status_q == ST_ACCEPTED)) |->
      (res_len_q >= LenW'(MinFrameBytes)))
    else $error("accepted frame shorter than the minimum");

endmodule

`default_nettype wire

// ===== hdl/mbrtu_crc_step.sv =====
`default_nettype none

module mbrtu_crc_step
  import mbrtu_pkg::*;
(
  input  logic [CrcW-1:0]  crc_i,
  input  logic [ByteW-1:0] data_i,
  output logic [CrcW-1:0]  crc_o
);

  // one byte through the reflected crc, eight bit steps
  always_comb begin
    logic [CrcW-1:0] c;
    c = crc_i ^ {{(CrcW-ByteW){1'b0}}, data_i};
    for (int k = 0; k < ByteW; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    crc_o = c;
  end

endmodule

`default_nettype wire

// ===== bench/mbrtu_verdict_checker.sv =====
`timescale 1ns / 100ps

package mbrtu_tb_pkg;
  import mbrtu_pkg::*;

  // one byte through the reflected modbus crc, lsb first
  function automatic logic [CrcW-1:0] crc16_step(logic [CrcW-1:0] crc, logic [ByteW-1:0] b);
    logic [CrcW-1:0] acc;
    acc = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      acc = acc[0] ? ((acc >> 1) ^ CrcPoly) : (acc >> 1);
    end
    return acc;
  endfunction
endpackage

module mbrtu_verdict_checker
  import mbrtu_pkg::*, mbrtu_tb_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  mbrtu_rx_if         rx_i,
  mbrtu_res_if        res_i,
  mbrtu_cfg_if        cfg_i,
  output int unsigned fail_count_o,
  output int unsigned verdicts_due_o,
  output int unsigned verdicts_seen_o
);

  typedef struct packed {
    frame_status_e     status;
    logic [ByteW-1:0]  address;
    logic [LenW-1:0]   length;
  } verdict_t;

  verdict_t due_verdicts[$];

  // frame state of the predictor
  logic [CrcW-1:0]   run_crc;
  logic [ByteW-1:0]  lag_old;
  logic [ByteW-1:0]  lag_new;
  logic [ByteW-1:0]  first_byte;
  logic [ByteW-1:0]  own_address;
  logic [CountW-1:0] byte_cnt;
  logic              too_long;
  int unsigned       mismatches;
  int unsigned       seen;

  task automatic restart_frame();
    run_crc    = CrcPreset;
    lag_old    = '0;
    lag_new    = '0;
    byte_cnt   = '0;
    first_byte = '0;
    too_long   = 1'b0;
  endtask

  // crc runs two bytes behind, so at the end it covers all but the trailer
  task automatic track_frame_byte(input logic [ByteW-1:0] b, input logic eof);
    verdict_t v;
    if (byte_cnt == 0) first_byte = b;
    if (byte_cnt >= 2) run_crc = crc16_step(run_crc, lag_old);
    lag_old = lag_new;
    lag_new = b;
    if (byte_cnt >= MaxFrameBytes) too_long = 1'b1;
    else byte_cnt++;
    if (eof) begin
      v.address = first_byte;
      v.length  = LenW'(byte_cnt);
      if (too_long) begin
        v.status = ST_OVERFLOW;
      end else if (byte_cnt < MinFrameBytes) begin
        v.status = ST_TOO_SHORT;
      end else if ({lag_new, lag_old} != run_crc) begin
        v.status = ST_CRC_ERROR;
      end else if (first_byte != own_address) begin
        v.status = ST_OTHER_ADR;
      end else begin
        v.status = ST_ACCEPTED;
      end
      due_verdicts.push_back(v);
      restart_frame();
    end
  endtask

  // compare one verdict request against the oldest prediction
  task automatic check_verdict();
    verdict_t want;
    seen++;
    if (due_verdicts.size() == 0) begin
      if (mismatches < 10)
        $display("verdict %0d unexpected: status %0d address %02h length %0d", seen,
                 res_i.frame_status, res_i.frame_address, res_i.frame_length);
      mismatches++;
    end else begin
      want = due_verdicts.pop_front();
      if (res_i.frame_status !== want.status || res_i.frame_address !== want.address ||
          res_i.frame_length !== want.length) begin
        if (mismatches < 10)
          $display("verdict %0d: expected status %0d address %02h length %0d, got %0d %02h %0d",
                   seen, want.status, want.address, want.length,
                   res_i.frame_status, res_i.frame_address, res_i.frame_length);
        mismatches++;
      end
    end
  endtask

  // results are taken before new bytes, a verdict never leaves in its own cycle
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_address = SlaveAddrReset;
      restart_frame();
      due_verdicts.delete();
      mismatches = 0;
      seen = 0;
    end else begin
      if (res_i.valid && res_i.ready) check_verdict();
      if (cfg_i.valid && cfg_i.ready) own_address = cfg_i.slave_address;
      if (rx_i.valid && rx_i.ready) track_frame_byte(rx_i.rx_byte, rx_i.end_of_frame);
    end
    fail_count_o    <= mismatches;
    verdicts_due_o  <= due_verdicts.size();
    verdicts_seen_o <= seen;
  end

endmodule

// ===== bench/tb_modbus_rtu_frame_checker.sv =====
`timescale 1ns / 100ps

module tb_modbus_rtu_frame_checker;
  import mbrtu_pkg::*;
  import mbrtu_tb_pkg::*;

  localparam int unsigned ClkPeriod     = 12;
  localparam int unsigned MaxWait       = 17;
  localparam int unsigned IdleLimit     = 2000;
  localparam int unsigned HoldOffCycles = 200;
  localparam int unsigned DrainPad      = 8;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  mbrtu_rx_if  rx_ch ();
  mbrtu_res_if res_ch ();
  mbrtu_cfg_if cfg_ch ();

  int unsigned fail_count;
  int unsigned verdicts_due;
  int unsigned verdicts_seen;

  // stimulus state
  logic [7:0]  frame_buf[$];
  logic [7:0]  slave_addr;
  bit          rx_lazy = 1'b1;
  bit          res_lazy = 1'b1;
  bit          hold_off_req = 1'b0;
  bit          hold_off_done = 1'b0;
  int unsigned bytes_sent = 0;
  int unsigned frames_sent = 0;
  int unsigned cfg_writes = 0;
  int unsigned longest_frame = 0;
  int unsigned idle_cycles;

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  modbus_rtu_frame_checker uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rx_i   (rx_ch),
    .res_o  (res_ch),
    .cfg_i  (cfg_ch)
  );

  mbrtu_verdict_checker checker_i (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .rx_i            (rx_ch),
    .res_i           (res_ch),
    .cfg_i           (cfg_ch),
    .fail_count_o    (fail_count),
    .verdicts_due_o  (verdicts_due),
    .verdicts_seen_o (verdicts_seen)
  );

  // one byte request, valid stays up when the next byte follows at once
  task automatic send_byte(input logic [7:0] b, input logic eof);
    int unsigned gap;
    gap = rx_lazy ? $urandom_range(0, MaxWait) : 0;
    if (gap != 0) begin
      rx_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    rx_ch.valid        <= 1'b1;
    rx_ch.rx_byte      <= b;
    rx_ch.end_of_frame <= eof;
    do @(posedge clk_i); while (!rx_ch.ready);
    bytes_sent++;
  endtask

  task automatic send_frame();
    foreach (frame_buf[i]) send_byte(frame_buf[i], i == frame_buf.size() - 1);
    frames_sent++;
    if (frame_buf.size() > longest_frame) longest_frame = frame_buf.size();
  endtask

  // address, random payload and a correct crc trailer, low byte first
  function automatic void build_frame(input logic [7:0] addr, input int unsigned payload_len);
    logic [15:0] crc;
    frame_buf.delete();
    frame_buf.push_back(addr);
    repeat (payload_len) frame_buf.push_back(8'($urandom));
    crc = CrcPreset;
    foreach (frame_buf[i]) crc = crc16_step(crc, frame_buf[i]);
    frame_buf.push_back(crc[7:0]);
    frame_buf.push_back(crc[15:8]);
  endfunction

  // mostly well-formed frames, some corrupted, short or pure noise
  task automatic random_frame();
    int unsigned kind;
    int unsigned idx;
    kind = $urandom_range(0, 99);
    if ($urandom_range(0, 3) == 0) rx_lazy = !rx_lazy;
    if (kind < 55) begin
      build_frame(slave_addr, $urandom_range(1, 10));
    end else if (kind < 70) begin
      build_frame(8'($urandom_range(0, 255)), $urandom_range(1, 10));
    end else if (kind < 85) begin
      build_frame(slave_addr, $urandom_range(0, 10));
      idx = $urandom_range(0, frame_buf.size() - 1);
      frame_buf[idx] ^= 8'(1 << $urandom_range(0, 7));
    end else begin
      frame_buf.delete();
      repeat (kind < 93 ? $urandom_range(1, 3) : $urandom_range(1, 12))
        frame_buf.push_back(8'($urandom));
    end
    send_frame();
  endtask

  task automatic random_frames(input int unsigned n);
    int unsigned start;
    start = bytes_sent;
    while (bytes_sent - start < n) random_frame();
  endtask

  // stop offering and wait until every verdict is back
  task automatic drain();
    rx_ch.valid <= 1'b0;
    do @(posedge clk_i); while (verdicts_due != 0);
    repeat (DrainPad) @(posedge clk_i);
  endtask

  task automatic write_slave_address(input logic [7:0] addr);
    cfg_ch.valid         <= 1'b1;
    cfg_ch.slave_address <= addr;
    do @(posedge clk_i); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    slave_addr = addr;
    cfg_writes++;
  endtask

  // stimulus and verdict
  initial begin
    rx_ch.valid          <= 1'b0;
    rx_ch.rx_byte        <= '0;
    rx_ch.end_of_frame   <= 1'b0;
    cfg_ch.valid         <= 1'b0;
    cfg_ch.slave_address <= '0;
    slave_addr = SlaveAddrReset;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // single byte and two byte frames are too short
    frame_buf = '{8'h00};
    send_frame();
    frame_buf = '{8'hFF, 8'h00};
    send_frame();
    // three bytes with a matching crc are still too short
    build_frame(slave_addr, 0);
    send_frame();
    // smallest frame that passes
    build_frame(slave_addr, 1);
    send_frame();
    // bad crc trailer
    build_frame(slave_addr, 1);
    frame_buf[frame_buf.size() - 1] ^= 8'h80;
    send_frame();
    // good crc, foreign address
    build_frame(8'hFF, 2);
    send_frame();
    // crc error wins over a foreign address
    build_frame(8'hFE, 1);
    frame_buf[1] ^= 8'h01;
    send_frame();
    drain();

    // address zero, then a frame at exactly the buffer bound
    write_slave_address(8'h00);
    random_frames(20);
    build_frame(slave_addr, MaxFrameBytes - 3);
    send_frame();
    drain();

    // address all ones with one overflowing frame in the middle
    write_slave_address(8'hFF);
    random_frames(15);
    build_frame(slave_addr, $urandom_range(MaxFrameBytes - 2, MaxFrameBytes + 14));
    send_frame();
    random_frames(15);
    drain();

    // long receiver hold-off while bytes keep coming
    write_slave_address(8'($urandom));
    hold_off_req = 1'b1;
    random_frames(120);
    drain();

    write_slave_address(8'($urandom_range(1, 254)));
    random_frames(20);
    drain();

    $display("sent %0d frames, %0d bytes, longest %0d, under %0d slave addresses",
             frames_sent, bytes_sent, longest_frame, cfg_writes + 1);
    $display("%0d verdicts compared, %0d still due", verdicts_seen, verdicts_due);
    if (fail_count + verdicts_due == 0) begin
      $display("modbus_rtu_frame_checker verification clean");
    end else begin
      $display("modbus_rtu_frame_checker verification failed");
    end
    $finish;
  end

  // result side, random stalls and one long hold-off
  initial begin
    int unsigned stall;
    res_ch.ready <= 1'b0;
    do @(posedge clk_i); while (!rst_ni);
    forever begin
      if (hold_off_req && !hold_off_done) begin
        res_ch.ready <= 1'b0;
        repeat (HoldOffCycles) @(posedge clk_i);
        hold_off_done = 1'b1;
      end else if (res_lazy) begin
        stall = $urandom_range(0, MaxWait);
        if (stall != 0) begin
          res_ch.ready <= 1'b0;
          repeat (stall) @(posedge clk_i);
        end
      end
      res_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!(res_ch.valid && res_ch.ready));
      if ($urandom_range(0, 15) == 0) res_lazy = !res_lazy;
    end
  end

  // watchdog on cycles without any request
  initial begin
    idle_cycles = 0;
    while (idle_cycles < IdleLimit) begin
      @(posedge clk_i);
      if ((rx_ch.valid && rx_ch.ready) || (res_ch.valid && res_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("no request for %0d cycles", IdleLimit);
    $display("modbus_rtu_frame_checker verification failed");
    $finish;
  end

endmodule

// ===== modbus_rtu_frame_checker.f =====
hdl/mbrtu_pkg.sv
hdl/mbrtu_if.sv
hdl/mbrtu_crc_step.sv
hdl/modbus_rtu_frame_checker.sv
bench/mbrtu_verdict_checker.sv
bench/tb_modbus_rtu_frame_checker.sv
